// ----- design/htbd_pkg.sv -----
// shared types and constants of the huffman tree bit decoder
package htbd_pkg;

  localparam int IDX_W     = 9;
  localparam int DATA_W    = 8;
  localparam int OUT_SYM_W = 8;
  localparam int TOTAL_W   = 32;
  localparam int CNT_W     = 4;
  localparam int REQ_W     = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_NODE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DATA = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

  localparam logic KIND_SYM = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [OUT_SYM_W-1:0] sym;
    logic                 status;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic load;
    logic shift;
  } shf_ctl_t;

endpackage

// ----- design/htbd_ram.sv -----
// generic single write port ram with registered read
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/htbd_bit_shift.sv -----
// data byte shift register, hands out one bit per step msb first
module htbd_bit_shift (
  input  logic                        clk,
  input  logic                        rst_n,
  input  htbd_pkg::shf_ctl_t          ctl,
  input  logic [htbd_pkg::DATA_W-1:0] din,
  output logic                        msb,
  output logic                        empty
);

  logic [htbd_pkg::DATA_W-1:0] sr_r, sr_nxt;
  logic [htbd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    sr_nxt  = sr_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      sr_nxt  = din;
      cnt_nxt = htbd_pkg::CNT_W'(htbd_pkg::DATA_W);
    end else if (ctl.shift && cnt_r != '0) begin
      sr_nxt  = {sr_r[htbd_pkg::DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  assign msb   = sr_r[htbd_pkg::DATA_W-1];
  assign empty = (cnt_r == '0);

endmodule

// ----- design/huffman_tree_bit_decoder_core.sv -----
// top level of the huffman tree walk decoder
//
// usage: the input stream carries one word per request, its kind in in_tuser
// (node write, data byte, end of stream) and the fields in in_tdata. node
// writes fill the node table while the block is idle. a data byte is walked msb
// first down the tree, one bit at a time, each step a registered node table
// read; a bit from a leaf root takes a root read and a node step, one to an
// inner node a node step and a child step, one to a leaf below both and a root
// read. in_tready stays low until the byte is done, or earlier once symbol_total
// symbols are out. each decoded symbol leaves on the output stream; the last
// word caused by a request carries out_tlast, and each symbol is held back
// until the next, so the final symbol of a byte can carry it. an end of stream
// request gives one status word (out_tuser high). in_tready is high only while
// no request is in progress. when the receiver stalls the walk pauses at the
// next symbol and resumes once the output register frees. reset clears the walk
// position and count and the registers, not the node table, which must be
// written before it is read. configuration words are taken on cfg_wr_en; the
// user must write them only while the block is idle; it does not enforce this.
module huffman_tree_bit_decoder_core #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node_index, node_leaf, node_symbol, node_left, node_right, data_byte
  input  logic [htbd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [htbd_pkg::REQ_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // decoded_symbol, end_status
  output logic [htbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // result_kind
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [htbd_pkg::TOTAL_W-1:0]     cfg_wdata
);

  localparam int IW    = htbd_pkg::IDX_W;
  localparam int AW    = $clog2(NODE_COUNT);
  localparam int XW    = (AW > IW) ? AW : IW;
  localparam int SYM_W = (SYMBOL_BITS < htbd_pkg::OUT_SYM_W) ? SYMBOL_BITS
                                                              : htbd_pkg::OUT_SYM_W;
  localparam int EW    = 1 + SYM_W + 2 * IW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CUR   = 3'd2;
  localparam logic [2:0] S_CHILD = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [IW-1:0]                  cur_node_r, cur_node_nxt;
  logic [IW-1:0]                  root_r, root_nxt;
  logic [htbd_pkg::TOTAL_W-1:0]   count_r, count_nxt;
  logic [htbd_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  htbd_pkg::res_t                 pend_r, pend_nxt;
  logic                           pend_v_r, pend_v_nxt;
  htbd_pkg::res_t                 out_r, out_nxt;
  logic                           out_v_r, out_v_nxt;
  logic                           oor_r;

  logic [IW-1:0]                  in_idx;
  logic                           in_leaf;
  logic [htbd_pkg::OUT_SYM_W-1:0] in_sym;
  logic [IW-1:0]                  in_left;
  logic [IW-1:0]                  in_right;
  logic [htbd_pkg::DATA_W-1:0]    in_byte;

  logic                           ram_we;
  logic [XW-1:0]                  wr_ext;
  logic [EW-1:0]                  ram_wdata;
  logic                           ram_re;
  logic [IW-1:0]                  rd_idx;
  logic [XW-1:0]                  rd_ext;
  logic                           rd_ok;
  logic [EW-1:0]                  ram_q;
  logic [EW-1:0]                  ent;
  logic                           ent_leaf;
  logic [SYM_W-1:0]               ent_sym;
  logic [IW-1:0]                  ent_left;
  logic [IW-1:0]                  ent_right;

  htbd_pkg::shf_ctl_t             shf_ctl;
  logic                           bit_msb;
  logic                           bits_empty;

  logic                           can_push;
  logic                           emit_ok;
  logic                           emit;
  logic                           finish;
  htbd_pkg::res_t                 emit_res;

  assign in_idx   = in_tdata[8:0];
  assign in_leaf  = in_tdata[9];
  assign in_sym   = in_tdata[17:10];
  assign in_left  = in_tdata[26:18];
  assign in_right = in_tdata[35:27];
  assign in_byte  = in_tdata[43:36];

  assign wr_ext    = XW'(in_idx);
  assign rd_ext    = XW'(rd_idx);
  assign rd_ok     = 32'(rd_idx) < 32'(NODE_COUNT);
  assign ram_wdata = {in_leaf, in_sym[SYM_W-1:0], in_left, in_right};

  htbd_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ext[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ext[AW-1:0]),
    .rdata (ram_q)
  );

  htbd_bit_shift u_bit_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (shf_ctl),
    .din   (in_byte),
    .msb   (bit_msb),
    .empty (bits_empty)
  );

  // out of range child reads as an all zero entry
  assign ent       = oor_r ? '0 : ram_q;
  assign ent_leaf  = ent[EW-1];
  assign ent_sym   = ent[EW-2 -: SYM_W];
  assign ent_left  = ent[2*IW-1 -: IW];
  assign ent_right = ent[IW-1:0];

  assign can_push = !out_v_r || out_tready;
  assign emit_ok  = !pend_v_r || can_push;

  always_comb begin
    state_nxt     = state_r;
    cur_node_nxt  = cur_node_r;
    root_nxt      = root_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rd_idx        = cur_node_r;
    shf_ctl.load  = 1'b0;
    shf_ctl.shift = 1'b0;
    emit          = 1'b0;
    finish        = 1'b0;
    emit_res.kind   = htbd_pkg::KIND_SYM;
    emit_res.sym    = htbd_pkg::OUT_SYM_W'(ent_sym);
    emit_res.status = 1'b0;
    emit_res.last   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            htbd_pkg::REQ_NODE: begin
              ram_we = 32'(in_idx) < 32'(NODE_COUNT);
            end
            htbd_pkg::REQ_DATA: begin
              shf_ctl.load = 1'b1;
              state_nxt    = S_RD;
            end
            htbd_pkg::REQ_END: begin
              pend_nxt.kind   = htbd_pkg::KIND_END;
              pend_nxt.sym    = '0;
              pend_nxt.status = (count_r != total_r);
              pend_nxt.last   = 1'b1;
              pend_v_nxt      = 1'b1;
              cur_node_nxt    = root_r;
              count_nxt       = '0;
              state_nxt       = S_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        rd_idx    = cur_node_r;
        state_nxt = S_CUR;
      end
      S_CUR: begin
        if (bits_empty || count_r >= total_r) begin
          state_nxt = S_FLUSH;
        end else if (ent_leaf) begin
          // leaf root, one symbol per bit
          if (emit_ok) begin
            emit          = 1'b1;
            count_nxt     = count_r + 1'b1;
            cur_node_nxt  = root_r;
            shf_ctl.shift = 1'b1;
            state_nxt     = S_RD;
          end
        end else begin
          rd_idx        = bit_msb ? ent_right : ent_left;
          cur_node_nxt  = rd_idx;
          ram_re        = 1'b1;
          shf_ctl.shift = 1'b1;
          state_nxt     = S_CHILD;
        end
      end
      S_CHILD: begin
        if (ent_leaf) begin
          if (emit_ok) begin
            emit         = 1'b1;
            count_nxt    = count_r + 1'b1;
            cur_node_nxt = root_r;
            state_nxt    = S_RD;
          end
        end else begin
          state_nxt = S_CUR;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (can_push) begin
          finish     = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end

    if (cfg_wr_en) begin
      case (cfg_index)
        htbd_pkg::CFG_ROOT: begin
          root_nxt     = cfg_wdata[IW-1:0];
          cur_node_nxt = cfg_wdata[IW-1:0];
        end
        htbd_pkg::CFG_TOTAL: begin
          total_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // output register, fed from the held back word
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_tready;
    if ((emit || finish) && pend_v_r) begin
      out_nxt      = pend_r;
      out_nxt.last = finish;
      out_v_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_node_r <= '0;
      root_r     <= '0;
      count_r    <= '0;
      total_r    <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_node_r <= cur_node_nxt;
      root_r     <= root_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (ram_re) begin
      oor_r <= !rd_ok;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_r.status, out_r.sym};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("held back word left over while idle");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == htbd_pkg::KIND_END |-> out_tlast)
    else $error("status word without tlast");

  a_child_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHILD |-> $past(state_r) == S_CUR || $past(state_r) == S_CHILD)
    else $error("child step not preceded by a node step");
`endif

endmodule
